[hdl/iso_mp_pkg.sv]
// ----------------------------------------------------------------------------
// ISO 8583 message parser package
// Shared types, framing constants and the data element format table.
// ----------------------------------------------------------------------------
package iso_mp_pkg;

   // Field and length widths
   localparam int FIELD_W  = 8;
   localparam int LEN_W    = 14;
   localparam int HCOUNT_W = 5;
   localparam int DIGIT_W  = 3;

   // Default length ceiling for variable elements
   localparam int MAX_FIELD_LENGTH = 9999;

   // Header framing: ignored length characters, MTI, two binary bitmaps
   localparam int HDR_SKIP         = 6;
   localparam int HDR_MTI_LAST     = 9;
   localparam int HDR_BITMAP_FIRST = 10;
   localparam int HDR_LAST         = 25;
   localparam int BITMAP_LAST_OFS  = 15;

   // Bitmap extent
   localparam int BITMAP_W    = 128;
   localparam int PRIMARY_TOP = 64;
   localparam int FIELD_TOP   = 128;

   // Field numbers reported for the header parts
   localparam logic [FIELD_W-1:0] FIELD_MTI    = 8'd0;
   localparam logic [FIELD_W-1:0] FIELD_BITMAP = 8'd1;

   // Input transaction payload
   typedef struct packed {
      logic [7:0] in_byte;
      logic       start_of_message;
   } req_type;

   // Result transaction payload
   typedef struct packed {
      logic [FIELD_W-1:0] field_number;
      logic [7:0]         out_byte;
      logic [LEN_W-1:0]   byte_offset;
      logic               last_of_field;
      logic               empty_field;
      logic               message_end;
   } rsp_type;

   // Data element format kinds
   typedef enum logic [1:0] {
      FMT_NONE  = 2'd0,
      FMT_FIXED = 2'd1,
      FMT_VAR   = 2'd2
   } fmt_kind_type;

   // Format of one element: fixed byte count or number of length digits
   typedef struct packed {
      fmt_kind_type kind;
      logic [3:0]   size;
   } fmt_type;

   // Look up the format of a data element
   function automatic fmt_type format_of(input logic [FIELD_W-1:0] f);
      fmt_type r;
      r.kind = FMT_NONE;
      r.size = 4'd0;
      case (f)
         8'd3, 8'd11, 8'd38: begin
            r.kind = FMT_FIXED; r.size = 4'd6;
         end
         8'd4, 8'd5, 8'd6: begin
            r.kind = FMT_FIXED; r.size = 4'd12;
         end
         8'd7: begin
            r.kind = FMT_FIXED; r.size = 4'd10;
         end
         8'd39: begin
            r.kind = FMT_FIXED; r.size = 4'd2;
         end
         8'd40: begin
            r.kind = FMT_FIXED; r.size = 4'd3;
         end
         8'd2, 8'd32, 8'd33, 8'd34, 8'd44, 8'd45, 8'd100, 8'd102, 8'd103,
         8'd105, 8'd107, 8'd108, 8'd109, 8'd118, 8'd122, 8'd123, 8'd124: begin
            r.kind = FMT_VAR; r.size = 4'd2;
         end
         8'd48, 8'd104, 8'd111, 8'd119, 8'd120, 8'd121: begin
            r.kind = FMT_VAR; r.size = 4'd3;
         end
         8'd127: begin
            r.kind = FMT_VAR; r.size = 4'd4;
         end
         default: begin
            r.kind = FMT_NONE; r.size = 4'd0;
         end
      endcase
      return r;
   endfunction

endpackage

[hdl/iso8583_message_parser.sv]
// ----------------------------------------------------------------------------
// ISO 8583 message parser
// Splits a byte stream into MTI, bitmap and data element bytes.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle unless a full result register is held, and
// gives at most one result per byte, so a steady stream runs at one byte per
// clock while results are taken. The input is taken whenever the result
// register is empty or is being drained in the same cycle. The longest path is
// the priority encoder over the 129-bit mask of present, formatted data elements
// that picks the next element at the end of each field. A start flag restarts
// the parser on that byte at any point; bytes before the first start and after
// the message end are dropped. A zero read length gives one empty marker result.
module iso8583_message_parser #(
   parameter int MAX_FIELD_LENGTH = iso_mp_pkg::MAX_FIELD_LENGTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  iso_mp_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output iso_mp_pkg::rsp_type rsp_data
);

   localparam int LW = iso_mp_pkg::LEN_W;
   localparam int FW = iso_mp_pkg::FIELD_W;
   localparam int HW = iso_mp_pkg::HCOUNT_W;
   localparam int DW = iso_mp_pkg::DIGIT_W;
   localparam int BW = iso_mp_pkg::BITMAP_W;
   localparam int FT = iso_mp_pkg::FIELD_TOP;
   localparam int PW = LW + 3;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_HEADER = 5'b00010,
      PH_LENGTH = 5'b00100,
      PH_DATA   = 5'b01000,
      PH_DONE   = 5'b10000
   } phase_type;

   phase_type           phase_ff, phase_in, eff_phase;
   logic [HW-1:0]       header_count_ff, header_count_in, eff_hc;
   logic [BW-1:0]       bitmap_ff, bitmap_in, bitmap_full;
   logic [FT:0]         pending_ff, pending_in, fresh_vec, enc_src;
   logic [FW-1:0]       current_field_ff, current_field_in;
   logic [DW-1:0]       digits_left_ff, digits_left_in;
   logic [LW-1:0]       length_ff, length_in;
   logic                number_ended_ff, number_ended_in;
   logic [LW-1:0]       data_count_ff, data_count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   iso_mp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                req_fire, emit, advance, hdr_end, is_digit;
   logic                enc_found;
   logic [FW-1:0]       enc_field;
   iso_mp_pkg::fmt_type next_fmt;
   logic [PW-1:0]       len_prod;
   logic [LW-1:0]       len_sat;
   logic [7:0]          b;

   // Handshake: the result register parts the two channels
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_fire  = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign b         = req_data.in_byte;

   // A start flag overrides the stored phase and header position
   assign eff_phase = req_data.start_of_message ? PH_HEADER : phase_ff;
   assign eff_hc    = req_data.start_of_message ? '0 : header_count_ff;
   assign hdr_end   = (eff_phase == PH_HEADER) && (eff_hc == HW'(iso_mp_pkg::HDR_LAST));

   // Complete bitmap as it stands on the last header byte
   assign bitmap_full = {bitmap_ff[BW-9:0], b};

   // Present and formatted elements of the fresh bitmap
   always_comb begin
      fresh_vec = '0;
      for (int p = 2; p <= FT; p++) begin
         fresh_vec[p] = bitmap_full[BW - p]
                        && (iso_mp_pkg::format_of(FW'(p)).kind != iso_mp_pkg::FMT_NONE)
                        && ((p <= iso_mp_pkg::PRIMARY_TOP) || bitmap_full[BW-1]);
      end
   end

   assign enc_src = hdr_end ? fresh_vec : pending_ff;

   // Find the lowest pending element
   always_comb begin
      enc_found = 1'b0;
      enc_field = '0;
      for (int p = FT; p >= 2; p--) begin
         if (enc_src[p]) begin
            enc_found = 1'b1;
            enc_field = FW'(p);
         end
      end
   end

   assign next_fmt = iso_mp_pkg::format_of(enc_field);

   // Accumulate one decimal length digit, saturating at the ceiling
   assign is_digit = ~number_ended_ff && (b >= 8'h30) && (b <= 8'h39);
   assign len_prod = (PW'(length_ff) << 3) + (PW'(length_ff) << 1) + PW'(b - 8'h30);
   assign len_sat  = (len_prod > PW'(MAX_FIELD_LENGTH)) ? LW'(MAX_FIELD_LENGTH)
                                                         : LW'(len_prod);

   // Next state and result for one input transaction
   always_comb begin
      phase_in         = phase_ff;
      header_count_in  = header_count_ff;
      bitmap_in        = bitmap_ff;
      pending_in       = pending_ff;
      current_field_in = current_field_ff;
      digits_left_in   = digits_left_ff;
      length_in        = length_ff;
      number_ended_in  = number_ended_ff;
      data_count_in    = data_count_ff;
      emit             = 1'b0;
      advance          = 1'b0;
      rsp_data_in      = '0;

      case (eff_phase)
         PH_HEADER: begin
            phase_in = PH_HEADER;
            if (eff_hc < HW'(iso_mp_pkg::HDR_SKIP)) begin
               header_count_in = eff_hc + 1'b1;
            end else if (eff_hc <= HW'(iso_mp_pkg::HDR_MTI_LAST)) begin
               emit                      = 1'b1;
               rsp_data_in.field_number  = iso_mp_pkg::FIELD_MTI;
               rsp_data_in.out_byte      = b;
               rsp_data_in.byte_offset   = LW'(eff_hc - HW'(iso_mp_pkg::HDR_SKIP));
               rsp_data_in.last_of_field = (eff_hc == HW'(iso_mp_pkg::HDR_MTI_LAST));
               header_count_in           = eff_hc + 1'b1;
            end else begin
               emit                     = 1'b1;
               bitmap_in                = bitmap_full;
               rsp_data_in.field_number = iso_mp_pkg::FIELD_BITMAP;
               rsp_data_in.out_byte     = b;
               rsp_data_in.byte_offset  =
                  LW'(eff_hc - HW'(iso_mp_pkg::HDR_BITMAP_FIRST));
               if (hdr_end) begin
                  rsp_data_in.last_of_field = 1'b1;
                  rsp_data_in.message_end   = ~enc_found;
                  advance                   = 1'b1;
               end else begin
                  header_count_in = eff_hc + 1'b1;
               end
            end
         end
         PH_LENGTH: begin
            if (is_digit) begin
               length_in = len_sat;
            end else begin
               number_ended_in = 1'b1;
            end
            digits_left_in = digits_left_ff - 1'b1;
            if (digits_left_ff == DW'(1)) begin
               if ((is_digit ? len_sat : length_ff) == '0) begin
                  emit                      = 1'b1;
                  rsp_data_in.field_number  = current_field_ff;
                  rsp_data_in.last_of_field = 1'b1;
                  rsp_data_in.empty_field   = 1'b1;
                  rsp_data_in.message_end   = ~enc_found;
                  advance                   = 1'b1;
               end else begin
                  phase_in      = PH_DATA;
                  data_count_in = '0;
               end
            end
         end
         PH_DATA: begin
            emit                     = 1'b1;
            rsp_data_in.field_number = current_field_ff;
            rsp_data_in.out_byte     = b;
            rsp_data_in.byte_offset  = data_count_ff;
            if ((LW'(1) + data_count_ff) >= length_ff) begin
               rsp_data_in.last_of_field = 1'b1;
               rsp_data_in.message_end   = ~enc_found;
               advance                   = 1'b1;
            end else begin
               data_count_in = data_count_ff + 1'b1;
            end
         end
         default: begin
            phase_in = eff_phase;
         end
      endcase

      // Open the next present element or finish the message
      if (advance) begin
         pending_in = enc_src & ~((FT+1)'(1) << enc_field);
         if (!enc_found) begin
            phase_in = PH_DONE;
         end else begin
            current_field_in = enc_field;
            data_count_in    = '0;
            number_ended_in  = 1'b0;
            if (next_fmt.kind == iso_mp_pkg::FMT_FIXED) begin
               phase_in       = PH_DATA;
               length_in      = LW'(next_fmt.size);
               digits_left_in = '0;
            end else begin
               phase_in       = PH_LENGTH;
               digits_left_in = DW'(next_fmt.size);
               length_in      = '0;
            end
         end
      end
   end

   // Hold the result until taken, load a new one on each emitting transaction
   always_comb begin
      if (req_fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         header_count_ff  <= '0;
         pending_ff       <= '0;
         current_field_ff <= '0;
         digits_left_ff   <= '0;
         length_ff        <= '0;
         number_ended_ff  <= 1'b0;
         data_count_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff         <= phase_in;
            header_count_ff  <= header_count_in;
            pending_ff       <= pending_in;
            current_field_ff <= current_field_in;
            digits_left_ff   <= digits_left_in;
            length_ff        <= length_in;
            number_ended_ff  <= number_ended_in;
            data_count_ff    <= data_count_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         bitmap_ff <= bitmap_in;
      end
      if (req_fire && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

[dv/iso8583_parse_checker.sv]
// ----------------------------------------------------------------------------
// ISO 8583 parser checker
// Watches both channels of the parser, predicts the field bytes that each
// accepted message byte produces and compares them with the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module iso8583_parse_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  iso_mp_pkg::req_type req_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  iso_mp_pkg::rsp_type rsp_data,
   output int                  mismatch_count,
   output int                  pending_count
);

   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_NINE = 8'h39;

   typedef enum logic [4:0] {
      PARSE_IDLE   = 5'b00001,
      PARSE_HEADER = 5'b00010,
      PARSE_LENGTH = 5'b00100,
      PARSE_DATA   = 5'b01000,
      PARSE_DONE   = 5'b10000
   } parse_phase_type;

   // Predicted parser state
   parse_phase_type                 phase;
   int                              header_pos;
   logic [0:iso_mp_pkg::BITMAP_W-1] presence;
   int                              element;
   int                              digits_left;
   int                              declared_len;
   bit                              digits_stopped;
   int                              data_pos;
   bit                              secondary;

   // Field bytes predicted but not yet seen on the result channel
   iso_mp_pkg::rsp_type field_bytes_due[$];

   // Byte count of a fixed-width element, 0 when not fixed
   function automatic int fixed_width(input int f);
      case (f)
         3, 11, 38: return 6;
         4, 5, 6:   return 12;
         7:         return 10;
         39:        return 2;
         40:        return 3;
         default:   return 0;
      endcase
   endfunction

   // Number of ASCII length digits of a variable element, 0 when not variable
   function automatic int length_digits(input int f);
      case (f)
         2, 32, 33, 34, 44, 45, 100, 102, 103, 105, 107, 108, 109,
         118, 122, 123, 124:                 return 2;
         48, 104, 111, 119, 120, 121:        return 3;
         127:                                return 4;
         default:                            return 0;
      endcase
   endfunction

   // First present element with a format after the given one, 0 if none
   function automatic int next_present(input int after);
      int limit;
      limit = secondary ? iso_mp_pkg::FIELD_TOP : iso_mp_pkg::PRIMARY_TOP;
      for (int f = after + 1; f <= limit; f++) begin
         if (f >= 2 && presence[f-1] && (fixed_width(f) != 0 || length_digits(f) != 0))
            return f;
      end
      return 0;
   endfunction

   // Set up the walk of one element, or finish the message
   function automatic void open_element(input int f);
      if (f == 0) begin
         phase = PARSE_DONE;
      end else begin
         element        = f;
         data_pos       = 0;
         digits_stopped = 1'b0;
         if (fixed_width(f) != 0) begin
            phase        = PARSE_DATA;
            declared_len = fixed_width(f);
            digits_left  = 0;
         end else begin
            phase        = PARSE_LENGTH;
            digits_left  = length_digits(f);
            declared_len = 0;
         end
      end
   endfunction

   function automatic void clear_parser();
      phase          = PARSE_IDLE;
      header_pos     = 0;
      presence       = '0;
      element        = 0;
      digits_left    = 0;
      declared_len   = 0;
      digits_stopped = 1'b0;
      data_pos       = 0;
      secondary      = 1'b0;
   endfunction

   function automatic iso_mp_pkg::rsp_type field_byte(input int fnum,
                                                      input logic [7:0] value,
                                                      input int offset, input bit last,
                                                      input bit empty, input bit fin);
      iso_mp_pkg::rsp_type r;
      r.field_number  = iso_mp_pkg::FIELD_W'(fnum);
      r.out_byte      = value;
      r.byte_offset   = iso_mp_pkg::LEN_W'(offset);
      r.last_of_field = last;
      r.empty_field   = empty;
      r.message_end   = fin;
      return r;
   endfunction

   // Advance the predicted parser by one message byte
   task automatic parse_byte(input iso_mp_pkg::req_type item, output bit made,
                             output iso_mp_pkg::rsp_type r);
      logic [7:0] b;
      int         nxt;
      b    = item.in_byte;
      made = 1'b0;
      r    = '0;
      if (item.start_of_message) begin
         clear_parser();
         phase = PARSE_HEADER;
      end
      case (phase)
         PARSE_HEADER: begin
            if (header_pos < iso_mp_pkg::HDR_SKIP) begin
               header_pos++;
            end else if (header_pos <= iso_mp_pkg::HDR_MTI_LAST) begin
               made = 1'b1;
               r = field_byte(int'(iso_mp_pkg::FIELD_MTI), b,
                              header_pos - iso_mp_pkg::HDR_SKIP,
                              header_pos == iso_mp_pkg::HDR_MTI_LAST, 1'b0, 1'b0);
               header_pos++;
            end else begin
               // bitmap bytes land MSB first, field 1 at the top
               presence[(header_pos - iso_mp_pkg::HDR_BITMAP_FIRST) * 8 +: 8] = b;
               made = 1'b1;
               if (header_pos < iso_mp_pkg::HDR_LAST) begin
                  r = field_byte(int'(iso_mp_pkg::FIELD_BITMAP), b,
                                 header_pos - iso_mp_pkg::HDR_BITMAP_FIRST,
                                 1'b0, 1'b0, 1'b0);
                  header_pos++;
               end else begin
                  secondary = presence[0];
                  nxt = next_present(1);
                  r = field_byte(int'(iso_mp_pkg::FIELD_BITMAP), b,
                                 iso_mp_pkg::BITMAP_LAST_OFS, 1'b1, 1'b0, nxt == 0);
                  open_element(nxt);
               end
            end
         end
         PARSE_LENGTH: begin
            // a non-digit freezes the length read so far
            if (!digits_stopped && b >= ASCII_ZERO && b <= ASCII_NINE) begin
               declared_len = declared_len * 10 + int'(b - ASCII_ZERO);
               if (declared_len > iso_mp_pkg::MAX_FIELD_LENGTH)
                  declared_len = iso_mp_pkg::MAX_FIELD_LENGTH;
            end else begin
               digits_stopped = 1'b1;
            end
            if (digits_left > 0)
               digits_left--;
            if (digits_left == 0) begin
               if (declared_len == 0) begin
                  nxt  = next_present(element);
                  made = 1'b1;
                  r = field_byte(element, 8'h00, 0, 1'b1, 1'b1, nxt == 0);
                  open_element(nxt);
               end else begin
                  phase    = PARSE_DATA;
                  data_pos = 0;
               end
            end
         end
         PARSE_DATA: begin
            made = 1'b1;
            if (data_pos + 1 >= declared_len) begin
               nxt = next_present(element);
               r = field_byte(element, b, data_pos, 1'b1, 1'b0, nxt == 0);
               open_element(nxt);
            end else begin
               r = field_byte(element, b, data_pos, 1'b0, 1'b0, 1'b0);
               data_pos++;
            end
         end
         default: begin
         end
      endcase
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Predict on each accepted byte, compare on each accepted result
   always @(posedge clock) begin
      iso_mp_pkg::rsp_type due;
      iso_mp_pkg::rsp_type produced;
      bit                  made;
      if (reset) begin
         clear_parser();
         field_bytes_due.delete();
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(req_data, made, produced);
            if (made)
               field_bytes_due.push_back(produced);
         end
         if (rsp_valid && rsp_ready) begin
            if (field_bytes_due.size() == 0) begin
               $error("unexpected transaction: field_number %0d out_byte %0d",
                      rsp_data.field_number, rsp_data.out_byte);
               mismatch_count++;
            end else begin
               due = field_bytes_due.pop_front();
               check_field("field_number", 32'(due.field_number),
                           32'(rsp_data.field_number));
               check_field("out_byte", 32'(due.out_byte), 32'(rsp_data.out_byte));
               check_field("byte_offset", 32'(due.byte_offset),
                           32'(rsp_data.byte_offset));
               check_field("last_of_field", 32'(due.last_of_field),
                           32'(rsp_data.last_of_field));
               check_field("empty_field", 32'(due.empty_field),
                           32'(rsp_data.empty_field));
               check_field("message_end", 32'(due.message_end),
                           32'(rsp_data.message_end));
            end
         end
      end
      pending_count = field_bytes_due.size();
   end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// ISO 8583 message parser testbench
// Feeds directed and random byte streams with random gaps and result stalls;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam int         TOTAL_BYTES = 550;
   localparam int         HOLD_CYCLES = 200;
   localparam int         STALL_LIMIT = 2000;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   iso_mp_pkg::req_type req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   iso_mp_pkg::rsp_type rsp_data;

   int mismatch_count;
   int pending_count;

   int         idle_cycles = 0;
   int         tx_burst = 0;
   int         bytes_sent;
   bit         hold_results = 1'b0;
   logic [7:0] message_bytes[$];

   always #5 clock = ~clock;

   iso8583_message_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   iso8583_parse_checker parse_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Wait before the next transaction: mostly short, sometimes a run of zeros
   function automatic int draw_gap(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst_left = $urandom_range(8, 40);
         return 0;
      end
      if ($urandom_range(0, 1) == 0)
         return $urandom_range(0, 2);
      return $urandom_range(0, 18);
   endfunction

   // Offer one byte after a random gap and hold it until accepted
   task automatic offer_byte(input logic [7:0] value, input bit first);
      iso_mp_pkg::req_type item;
      int                  gap;
      item.in_byte          = value;
      item.start_of_message = first;
      gap = draw_gap(tx_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Send the first count bytes of the built message, start flag on the first
   task automatic send_message(input int count);
      for (int k = 0; k < count; k++) begin
         offer_byte(message_bytes[k], k == 0);
      end
   endtask

   task automatic send_noise(input int count);
      repeat (count) offer_byte(8'($urandom), 1'b0);
   endtask

   // Build a message for the given bitmap; var_len < 0 picks lengths at random
   task automatic compose_message(input logic [0:iso_mp_pkg::BITMAP_W-1] bits,
                                  input int var_len);
      iso_mp_pkg::fmt_type layout;
      int                  n;
      int                  limit;
      message_bytes.delete();
      // length characters and MTI
      repeat (iso_mp_pkg::HDR_SKIP + 4) message_bytes.push_back(8'($urandom));
      for (int k = 0; k < 16; k++)
         message_bytes.push_back(bits[k*8 +: 8]);
      limit = bits[0] ? iso_mp_pkg::FIELD_TOP : iso_mp_pkg::PRIMARY_TOP;
      for (int f = 2; f <= limit; f++) begin
         if (bits[f-1]) begin
            layout = iso_mp_pkg::format_of(iso_mp_pkg::FIELD_W'(f));
            n = 0;
            if (layout.kind == iso_mp_pkg::FMT_FIXED) begin
               n = int'(layout.size);
            end else if (layout.kind == iso_mp_pkg::FMT_VAR) begin
               if (var_len >= 0)
                  n = var_len;
               else if ($urandom_range(0, 9) == 0)
                  n = $urandom_range(5, 40);
               else
                  n = $urandom_range(0, 4);
               for (int d = int'(layout.size) - 1; d >= 0; d--)
                  message_bytes.push_back(ASCII_ZERO + 8'((n / (10 ** d)) % 10));
            end
            repeat (n) message_bytes.push_back(8'($urandom));
         end
      end
   endtask

   // Receiver: random stall per transaction, one long hold-off on request
   initial begin
      int stall;
      int rx_burst;
      int held;
      rx_burst = 0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_results) begin
            rsp_ready <= 1'b0;
            held = 0;
            while (held < HOLD_CYCLES) begin
               @(negedge clock);
               held++;
            end
            hold_results = 1'b0;
         end
         stall = draw_gap(rx_burst);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("iso8583_message_parser test failed");
            $finish;
         end
      end
   end

   initial begin
      logic [0:iso_mp_pkg::BITMAP_W-1] bits;
      iso_mp_pkg::fmt_type             layout;
      int                              round;
      int                              shape;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drop bytes before any start
      offer_byte(8'h00, 1'b0);
      offer_byte(8'hFF, 1'b0);
      send_noise(2);

      // only unformatted elements: message ends on the bitmap, then drop
      bits = '0;
      bits[7]  = 1'b1;
      bits[63] = 1'b1;
      compose_message(bits, 0);
      send_message(message_bytes.size());
      send_noise(3);

      // every element present, all variable lengths zero
      bits = '1;
      compose_message(bits, 0);
      message_bytes[iso_mp_pkg::HDR_SKIP]     = 8'h00;
      message_bytes[iso_mp_pkg::HDR_SKIP + 1] = 8'hFF;
      send_message(message_bytes.size());

      // sender pause until every result is back
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);

      // length digits cut short: field 2 reads "3x", field 127 uses four digits
      bits = '0;
      bits[0]   = 1'b1;
      bits[1]   = 1'b1;
      bits[126] = 1'b1;
      compose_message(bits, 3);
      message_bytes[iso_mp_pkg::HDR_LAST + 1] = ASCII_ZERO + 8'd3;
      message_bytes[iso_mp_pkg::HDR_LAST + 2] = 8'h78;
      send_message(message_bytes.size());

      // leading blank gives a zero length and an empty last field
      bits = '0;
      bits[1] = 1'b1;
      compose_message(bits, 0);
      message_bytes[iso_mp_pkg::HDR_LAST + 1] = 8'h20;
      send_message(message_bytes.size());

      // restart in the middle of a message
      bits = '0;
      bits[2] = 1'b1;
      bits[3] = 1'b1;
      compose_message(bits, 0);
      send_message(iso_mp_pkg::HDR_LAST + 5);
      send_message(message_bytes.size());

      // random messages, some broken or cut short
      round = 0;
      while (bytes_sent < TOTAL_BYTES) begin
         for (int f = 2; f <= iso_mp_pkg::FIELD_TOP; f++) begin
            layout = iso_mp_pkg::format_of(iso_mp_pkg::FIELD_W'(f));
            if (layout.kind != iso_mp_pkg::FMT_NONE)
               bits[f-1] = ($urandom_range(0, 3) == 0);
            else
               bits[f-1] = ($urandom_range(0, 11) == 0);
         end
         bits[0] = 1'($urandom_range(0, 1));
         compose_message(bits, -1);
         shape = $urandom_range(0, 9);
         if (shape == 0 && message_bytes.size() > iso_mp_pkg::HDR_LAST + 1)
            message_bytes[$urandom_range(iso_mp_pkg::HDR_LAST + 1,
                                         message_bytes.size() - 1)] = 8'($urandom);
         if (round == 1)
            hold_results = 1'b1;
         if (shape == 1)
            send_message($urandom_range(1, message_bytes.size() - 1));
         else
            send_message(message_bytes.size());
         if (shape == 2)
            send_noise($urandom_range(1, 3));
         round++;
      end

      // drain and let the pipeline settle
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      if (mismatch_count == 0)
         $display("iso8583_message_parser test passed");
      else
         $display("iso8583_message_parser test failed");
      $finish;
   end

endmodule

[filelist.f]
hdl/iso_mp_pkg.sv
hdl/iso8583_message_parser.sv
dv/iso8583_parse_checker.sv
dv/testbench.sv
